// ----- src/slsl_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sorted loss sequence list: sizes, request and status codes,
// cell control types and the windowed sequence order functions. No dependencies.
package slsl_pkg;

  localparam int CAPACITY   = 256;
  localparam int SEQ_WINDOW = 1048576;

  localparam int SEQ_W     = 31;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 9;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DIFF_W    = SEQ_W + 1;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic signed [DIFF_W-1:0] WIN_POS = DIFF_W'(SEQ_WINDOW);
  localparam logic signed [DIFF_W-1:0] WIN_NEG = -WIN_POS;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
  localparam logic [OP_W-1:0] OP_CMP    = 3'd1;
  localparam logic [OP_W-1:0] OP_LINK   = 3'd2;
  localparam logic [OP_W-1:0] OP_COMMIT = 3'd3;
  localparam logic [OP_W-1:0] OP_SHL    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEQ_W-1:0] seq;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  typedef struct packed {
    logic stop;
    logic dup;
  } link_t;

  function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
    logic signed [DIFF_W-1:0] diff;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    return ((diff > 0) && (diff < WIN_POS)) || (diff < WIN_NEG);
  endfunction

  function automatic logic seq_covered(input logic [SEQ_W-1:0] e,
                                       input logic [SEQ_W-1:0] s);
    logic signed [DIFF_W-1:0] diff;
    diff = $signed({1'b0, s}) - $signed({1'b0, e});
    return ((diff >= 0) && (diff < WIN_POS)) || (diff < WIN_NEG);
  endfunction

endpackage

// ----- src/slsl_cell.sv -----
`timescale 1ns / 1ps
// One cell of the loss list chain: holds one entry, compares it with the
// request number and shifts with its neighbors. Depends on slsl_pkg.
module slsl_cell (
  input  logic                       clk,
  input  slsl_pkg::cell_ctl_t        ctl,
  input  logic [slsl_pkg::CNT_W-1:0] idx,
  input  logic [slsl_pkg::SEQ_W-1:0] left_val,
  input  logic [slsl_pkg::SEQ_W-1:0] right_val,
  input  slsl_pkg::link_t            link_in,
  output slsl_pkg::link_t            link_out,
  output logic [slsl_pkg::SEQ_W-1:0] val
);

  logic [slsl_pkg::SEQ_W-1:0] val_r;
  logic                       pass_r;
  logic                       eq_r;
  logic                       first_r;
  logic                       after_r;
  logic                       occ;

  assign occ = idx < ctl.count;
  assign val = val_r;

  assign link_out.stop = link_in.stop | ~pass_r;
  assign link_out.dup  = link_in.dup | (~link_in.stop & ~pass_r & eq_r);

  always_ff @(posedge clk) begin
    case (ctl.op)
      slsl_pkg::OP_CMP: begin
        pass_r <= occ && slsl_pkg::seq_before(val_r, ctl.seq);
        eq_r   <= occ && (val_r == ctl.seq);
      end
      slsl_pkg::OP_LINK: begin
        first_r <= ~link_in.stop & ~pass_r;
        after_r <= link_in.stop;
      end
      slsl_pkg::OP_COMMIT: begin
        if (after_r) begin
          val_r <= left_val;
        end else if (first_r) begin
          val_r <= ctl.seq;
        end
      end
      slsl_pkg::OP_SHL: begin
        val_r <= right_val;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/sorted_loss_sequence_list.sv -----
`timescale 1ns / 1ps
// Top level of the sorted loss sequence list: request sequencer, result
// register and the chain of slsl_cell entries. Depends on slsl_pkg, slsl_cell.
//
//   channel | ports                                               | direction
//   in      | in_valid, in_stall, in_req_type, in_seq_no          | request in
//   out     | out_valid, out_stall, out_status, out_popped_seq,   | result out
//           | out_entry_count, out_removed_count                  |
//
// One request is worked at a time; the input is stalled until its result is
// in the output register. An insert steps through the compare, link and
// commit states. A pop is worked in the pop state. A remove-through drops
// the covered entries from the head, as the chain compacts by one cell a
// cycle. Reset is synchronous and empties the list at once. A stalled
// result holds the sequencer in its final state.
module sorted_loss_sequence_list (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [slsl_pkg::REQ_W-1:0]     in_req_type,
  input  logic [slsl_pkg::SEQ_W-1:0]     in_seq_no,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [slsl_pkg::STATUS_W-1:0]  out_status,
  output logic [slsl_pkg::SEQ_W-1:0]     out_popped_seq,
  output logic [slsl_pkg::OUT_CNT_W-1:0] out_entry_count,
  output logic [slsl_pkg::OUT_CNT_W-1:0] out_removed_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;
  localparam logic [2:0] S_LINK   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_REM    = 3'd4;
  localparam logic [2:0] S_POP    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                        state_r, state_nxt;
  logic [slsl_pkg::SEQ_W-1:0]        seq_r, seq_nxt;
  logic [slsl_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [slsl_pkg::CNT_W-1:0]        removed_r, removed_nxt;
  logic [slsl_pkg::STATUS_W-1:0]     status_r, status_nxt;
  logic [slsl_pkg::SEQ_W-1:0]        popped_r, popped_nxt;
  logic                              dup_r, dup_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [slsl_pkg::STATUS_W-1:0]     out_status_r;
  logic [slsl_pkg::SEQ_W-1:0]        out_popped_r;
  logic [slsl_pkg::OUT_CNT_W-1:0]    out_entry_r;
  logic [slsl_pkg::OUT_CNT_W-1:0]    out_removed_r;
  logic                              load_out;
  logic [slsl_pkg::OP_W-1:0]         cell_op;
  slsl_pkg::cell_ctl_t               ctl;
  logic [slsl_pkg::SEQ_W-1:0]        cell_val [slsl_pkg::CAPACITY];
  slsl_pkg::link_t                   chain [slsl_pkg::CAPACITY+1];
  logic [slsl_pkg::SEQ_W-1:0]        head;

  assign head = cell_val[0];

  assign ctl.op    = cell_op;
  assign ctl.seq   = seq_r;
  assign ctl.count = count_r;

  assign chain[0].stop = 1'b0;
  assign chain[0].dup  = 1'b0;

  for (genvar i = 0; i < slsl_pkg::CAPACITY; i++) begin : g_cell
    logic [slsl_pkg::SEQ_W-1:0] left_v;
    logic [slsl_pkg::SEQ_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_val[i];
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == slsl_pkg::CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end
    slsl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (slsl_pkg::CNT_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .link_in   (chain[i]),
      .link_out  (chain[i+1]),
      .val       (cell_val[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    seq_nxt     = seq_r;
    count_nxt   = count_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    popped_nxt  = popped_r;
    dup_nxt     = dup_r;
    cell_op     = slsl_pkg::OP_HOLD;
    load_out    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          seq_nxt     = in_seq_no;
          removed_nxt = '0;
          popped_nxt  = '0;
          case (in_req_type)
            slsl_pkg::REQ_INSERT: state_nxt = S_CMP;
            slsl_pkg::REQ_REMOVE: state_nxt = S_REM;
            default:              state_nxt = S_POP;
          endcase
        end
      end
      S_CMP: begin
        cell_op   = slsl_pkg::OP_CMP;
        state_nxt = S_LINK;
      end
      S_LINK: begin
        cell_op   = slsl_pkg::OP_LINK;
        dup_nxt   = chain[slsl_pkg::CAPACITY].dup;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (dup_r) begin
          status_nxt = slsl_pkg::ST_DUPLICATE;
        end else if (count_r == slsl_pkg::CAP_CNT) begin
          status_nxt = slsl_pkg::ST_FULL;
        end else begin
          cell_op    = slsl_pkg::OP_COMMIT;
          count_nxt  = count_r + 1'b1;
          status_nxt = slsl_pkg::ST_INSERTED;
        end
        state_nxt = S_DONE;
      end
      S_REM: begin
        if ((count_r != '0) && slsl_pkg::seq_covered(head, seq_r)) begin
          cell_op     = slsl_pkg::OP_SHL;
          count_nxt   = count_r - 1'b1;
          removed_nxt = removed_r + 1'b1;
        end else begin
          status_nxt = slsl_pkg::ST_REMOVED;
          state_nxt  = S_DONE;
        end
      end
      S_POP: begin
        if (count_r == '0) begin
          status_nxt = slsl_pkg::ST_EMPTY;
        end else begin
          cell_op    = slsl_pkg::OP_SHL;
          popped_nxt = head;
          count_nxt  = count_r - 1'b1;
          status_nxt = slsl_pkg::ST_POPPED;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r     <= seq_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    popped_r  <= popped_nxt;
    dup_r     <= dup_nxt;
    if (load_out) begin
      out_status_r  <= status_r;
      out_popped_r  <= popped_r;
      out_entry_r   <= slsl_pkg::OUT_CNT_W'(count_r);
      out_removed_r <= slsl_pkg::OUT_CNT_W'(removed_r);
    end
  end

  assign in_stall          = state_r != S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_popped_seq    = out_popped_r;
  assign out_entry_count   = out_entry_r;
  assign out_removed_count = out_removed_r;

endmodule
